[hw/rtl/pee_pkg.sv]
package pee_pkg;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam int unsigned ERR_W = 3;

	localparam logic [ERR_W-1:0] ERR_NONE      = 3'd0;
	localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 3'd1;
	localparam logic [ERR_W-1:0] ERR_OPERATORS = 3'd2;
	localparam logic [ERR_W-1:0] ERR_DIV_ZERO  = 3'd3;
	localparam logic [ERR_W-1:0] ERR_MOD_ZERO  = 3'd4;
	localparam logic [ERR_W-1:0] ERR_BAD_CHAR  = 3'd5;
	localparam logic [ERR_W-1:0] ERR_LEFTOVER  = 3'd6;

	localparam int unsigned WORD_W = 32;

	typedef enum logic [2:0] {
		OP_ADD,
		OP_SUB,
		OP_MUL,
		OP_DIV,
		OP_MOD,
		OP_POW
	} op_t;

endpackage

[hw/rtl/pee_char_if.sv]
interface pee_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink (input valid, input char_code, input last_char, output ready);
endinterface

[hw/rtl/pee_result_if.sv]
interface pee_result_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] value;
	logic [2:0]         error_code;

	modport source (output valid, output value, output error_code, input ready);
	modport sink (input valid, input value, input error_code, output ready);
endinterface

[hw/rtl/postfix_expression_evaluator.sv]
// Channel   Direction  Payload                        Transaction
// chars     sink       char_code[7:0], last_char      one character of the expression
// results   source     value[31:0] signed, error_code one result per last character
//
// A digit, a space or an invalid character is taken in ST_IDLE; + - * pass through ST_RDL,
// ST_EXEC and ST_WB. Division and modulo run the 32-step restoring divider, then ST_DFIN.
// Power loops in ST_POW: the shared multiplier alternates between the
// accumulator and the square once per exponent bit. A last character ends in ST_DONE.
// Reset clears the stack count, the error latch and the state; the stack memory is not cleared.
// A finished result waits in an output register while later characters are taken.
module postfix_expression_evaluator
	import pee_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = 15
) (
	input  logic       clk,
	input  logic       arst_n,
	pee_char_if.sink   chars,
	pee_result_if.source results
);

	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
	localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int unsigned DIV_STEPS = 32;
	localparam int unsigned SW = $clog2(DIV_STEPS);

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_RDL  = 8'b0000_0010,
		ST_EXEC = 8'b0000_0100,
		ST_DIV  = 8'b0000_1000,
		ST_DFIN = 8'b0001_0000,
		ST_POW  = 8'b0010_0000,
		ST_WB   = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} state_t;

	function automatic logic [WORD_W-1:0] mag(input logic [WORD_W-1:0] v);
		return v[WORD_W-1] ? (-v) : v;
	endfunction

	state_t state_q;
	logic [CW-1:0] count_q;
	logic [ERR_W-1:0] err_q;
	logic out_valid_q;
	logic [SW-1:0] step_q;
	logic pow_odd_q;

	logic last_q;
	op_t op_q;
	logic [WORD_W-1:0] right_q, res_q, bottom_q;
	logic [WORD_W-1:0] quo_q, rem_q, dvs_q;
	logic qneg_q, aneg_q;
	logic [WORD_W-1:0] acc_q, sq_q, exp_q;
	logic [WORD_W-1:0] out_value_q;
	logic [ERR_W-1:0] out_err_q;

	logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
	logic [WORD_W-1:0] rd_data_q;

	logic accept, out_free;
	logic is_digit, is_op, is_space, too_few, full;
	op_t dec_op;
	logic [7:0] digit;
	logic [CW-1:0] cnt_m1, cnt_m2;
	logic wr_en;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [WORD_W-1:0] wr_data;
	logic [WORD_W-1:0] mul_a, mul_b, mul_p;
	logic [2*WORD_W-1:0] mul_full;
	logic [WORD_W:0] rem_shift, rem_diff;
	logic div_ge;
	logic [WORD_W-1:0] pow_special;
	state_t end_state;

	assign chars.ready = (state_q == ST_IDLE);
	assign accept = chars.valid && chars.ready;
	assign out_free = !out_valid_q || results.ready;
	assign results.valid = out_valid_q;
	assign results.value = out_value_q;
	assign results.error_code = out_err_q;

	assign digit = chars.char_code - CH_ZERO;
	assign is_digit = (chars.char_code >= CH_ZERO) && (chars.char_code <= CH_NINE);
	assign is_space = (chars.char_code == CH_SPACE);
	assign cnt_m1 = count_q - CW'(1);
	assign cnt_m2 = count_q - CW'(2);
	assign too_few = (count_q < CW'(2));
	assign full = (count_q >= CW'(STACK_DEPTH));
	assign end_state = last_q ? ST_DONE : ST_IDLE;

	always_comb begin
		is_op = 1'b1;
		dec_op = OP_ADD;
		unique case (chars.char_code)
			CH_PLUS: dec_op = OP_ADD;
			CH_MINUS: dec_op = OP_SUB;
			CH_STAR: dec_op = OP_MUL;
			CH_SLASH: dec_op = OP_DIV;
			CH_PCT: dec_op = OP_MOD;
			CH_CARET: dec_op = OP_POW;
			default: is_op = 1'b0;
		endcase
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = count_q[AW-1:0];
		wr_data = {24'd0, digit};
		if (state_q == ST_WB) begin
			wr_en = 1'b1;
			wr_addr = cnt_m2[AW-1:0];
			wr_data = res_q;
		end else if (accept && (err_q == ERR_NONE) && is_digit && !full) begin
			wr_en = 1'b1;
		end
	end

	assign rd_addr = (state_q == ST_IDLE) ? cnt_m1[AW-1:0] : cnt_m2[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			stack_mem[wr_addr] <= wr_data;
		end
		rd_data_q <= stack_mem[rd_addr];
	end

	always_comb begin
		if (state_q == ST_EXEC) begin
			mul_a = rd_data_q;
			mul_b = right_q;
		end else if (!pow_odd_q) begin
			mul_a = acc_q;
			mul_b = sq_q;
		end else begin
			mul_a = sq_q;
			mul_b = sq_q;
		end
	end

	assign mul_full = mul_a * mul_b;
	assign mul_p = mul_full[WORD_W-1:0];

	assign rem_shift = {rem_q, quo_q[WORD_W-1]};
	assign rem_diff = rem_shift - {1'b0, dvs_q};
	assign div_ge = (rem_shift >= {1'b0, dvs_q});

	always_comb begin
		if (rd_data_q == WORD_W'(1)) begin
			pow_special = WORD_W'(1);
		end else if (rd_data_q == {WORD_W{1'b1}}) begin
			pow_special = right_q[0] ? {WORD_W{1'b1}} : WORD_W'(1);
		end else begin
			pow_special = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			err_q <= ERR_NONE;
			out_valid_q <= 1'b0;
			step_q <= '0;
			pow_odd_q <= 1'b0;
		end else begin
			if (results.ready && !(state_q == ST_DONE && out_free)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (err_q == ERR_NONE && is_digit) begin
							if (full) begin
								err_q <= ERR_OVERFLOW;
							end else begin
								count_q <= count_q + CW'(1);
							end
						end else if (err_q == ERR_NONE && is_op && too_few) begin
							err_q <= ERR_OPERATORS;
						end else if (err_q == ERR_NONE && !is_op && !is_space) begin
							err_q <= ERR_BAD_CHAR;
						end
						if (err_q == ERR_NONE && is_op && !too_few) begin
							state_q <= ST_RDL;
						end else if (chars.last_char) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_RDL: state_q <= ST_EXEC;
				ST_EXEC: begin
					unique case (op_q)
						OP_DIV: begin
							if (right_q == '0) begin
								err_q <= ERR_DIV_ZERO;
								state_q <= end_state;
							end else begin
								step_q <= '0;
								state_q <= ST_DIV;
							end
						end
						OP_MOD: begin
							if (right_q == '0) begin
								err_q <= ERR_MOD_ZERO;
								state_q <= end_state;
							end else begin
								step_q <= '0;
								state_q <= ST_DIV;
							end
						end
						OP_POW: begin
							pow_odd_q <= 1'b0;
							state_q <= right_q[WORD_W-1] ? ST_WB : ST_POW;
						end
						default: state_q <= ST_WB;
					endcase
				end
				ST_DIV: begin
					step_q <= step_q + SW'(1);
					if (step_q == SW'(DIV_STEPS - 1)) begin
						state_q <= ST_DFIN;
					end
				end
				ST_DFIN: state_q <= ST_WB;
				ST_POW: begin
					pow_odd_q <= !pow_odd_q;
					if (pow_odd_q && (exp_q[WORD_W-1:1] == '0)) begin
						state_q <= ST_WB;
					end
				end
				ST_WB: begin
					count_q <= cnt_m1;
					state_q <= end_state;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						count_q <= '0;
						err_q <= ERR_NONE;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && (wr_addr == '0)) begin
			bottom_q <= wr_data;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					last_q <= chars.last_char;
					op_q <= dec_op;
				end
			end
			ST_RDL: right_q <= rd_data_q;
			ST_EXEC: begin
				unique case (op_q)
					OP_ADD: res_q <= rd_data_q + right_q;
					OP_SUB: res_q <= rd_data_q - right_q;
					OP_MUL: res_q <= mul_p;
					OP_DIV, OP_MOD: begin
						rem_q <= '0;
						quo_q <= mag(rd_data_q);
						dvs_q <= mag(right_q);
						qneg_q <= rd_data_q[WORD_W-1] ^ right_q[WORD_W-1];
						aneg_q <= rd_data_q[WORD_W-1];
					end
					OP_POW: begin
						res_q <= pow_special;
						acc_q <= WORD_W'(1);
						sq_q <= rd_data_q;
						exp_q <= right_q;
					end
					default: res_q <= '0;
				endcase
			end
			ST_DIV: begin
				rem_q <= div_ge ? rem_diff[WORD_W-1:0] : rem_shift[WORD_W-1:0];
				quo_q <= {quo_q[WORD_W-2:0], div_ge};
			end
			ST_DFIN: begin
				if (op_q == OP_DIV) begin
					res_q <= qneg_q ? (-quo_q) : quo_q;
				end else begin
					res_q <= aneg_q ? (-rem_q) : rem_q;
				end
			end
			ST_POW: begin
				if (!pow_odd_q) begin
					if (exp_q[0]) begin
						acc_q <= mul_p;
					end
				end else begin
					sq_q <= mul_p;
					exp_q <= exp_q >> 1;
					res_q <= acc_q;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					if (err_q != ERR_NONE) begin
						out_err_q <= err_q;
						out_value_q <= '0;
					end else if (count_q != CW'(1)) begin
						out_err_q <= ERR_LEFTOVER;
						out_value_q <= '0;
					end else begin
						out_err_q <= ERR_NONE;
						out_value_q <= bottom_q;
					end
				end
			end
			default: begin
			end
		endcase
	end

	// The stack count never passes the stack depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count exceeds depth");

	// Emitting a result clears the count and the error latch for the next expression.
	a_done_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && out_free) |=> (count_q == '0 && err_q == ERR_NONE))
		else $error("expression state not cleared after result");

	// The divider never runs on a zero divisor.
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (dvs_q != '0))
		else $error("divider running with zero divisor");

	// Once an error is latched, later characters leave the stack untouched.
	a_err_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && err_q != ERR_NONE) |=> $stable(count_q))
		else $error("stack changed after latched error");

endmodule
